[hdl/assert_macros.svh]
// assertion macros for the rtl files
// no dependencies; expects a clock and a synchronous reset at the use site
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fplog_pkg.sv]
// constants and helpers for the fixed-point logarithm unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fplog_pkg;

  localparam int FRAC    = 10;
  localparam int X_W     = 32;
  localparam int MODE_W  = 2;
  localparam int RES_W   = 16;
  localparam int N_W     = 5;
  localparam int M_W     = 10;
  localparam int L2_W    = 17;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W = 24;
  localparam int DIV_W   = 12;

  localparam logic [MODE_W-1:0] MODE_LOG2  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOG10 = 2'd2;

  localparam logic [14:0] POLY_C1 = 15'd28610;
  localparam logic [15:0] POLY_C2 = 16'd60718;
  localparam logic [15:0] POLY_C3 = 16'd59463;
  localparam logic [14:0] POLY_C4 = 15'd21202;
  localparam int          LOG2_OFFSET = 6163;

  localparam logic [DIV_W-1:0] LN_DIV    = 12'd1477;
  localparam logic [DIV_W-1:0] LOG10_DIV = 12'd3401;

  localparam logic [RECIP_W-1:0] LN_RECIP =
    RECIP_W'((64'd1 << (RECIP_SHIFT + FRAC)) / LN_DIV);
  localparam logic [RECIP_W-1:0] LOG10_RECIP =
    RECIP_W'((64'd1 << (RECIP_SHIFT + FRAC)) / LOG10_DIV);

  function automatic logic [RECIP_W-1:0] recip_sel(input logic [MODE_W-1:0] md);
    logic [RECIP_W-1:0] r;
    case (md)
      MODE_LN:    r = LN_RECIP;
      MODE_LOG10: r = LOG10_RECIP;
      default:    r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DIV_W-1:0] div_sel(input logic [MODE_W-1:0] md);
    logic [DIV_W-1:0] d;
    case (md)
      MODE_LN:    d = LN_DIV;
      MODE_LOG10: d = LOG10_DIV;
      default:    d = '0;
    endcase
    return d;
  endfunction

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [RES_W+1:0] v);
    logic signed [RES_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/fixed_point_logarithm_unit.sv]
// fixed-point log2 / ln / log10 unit, eight register stages
// depends on fplog_pkg and assert_macros.svh
//
//  channel | signals                          | direction
//  in      | in_valid, in_stall, x_raw, mode  | operand beat in
//  out     | out_valid, out_stall, result_raw,| result beat out
//          | invalid                          |
//
// an accepted beat passes every stage to out_valid; one beat per cycle while out_stall is low
// the stages: leading-one search, normalize, square, fourth power and products,
// poly products, log2 sum, reciprocal multiply, remainder fix-up and output
// rst clears the stage valid bits only
// stages with no beat fill in under a stall; in_stall rises only when all are full
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_logarithm_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [fplog_pkg::X_W-1:0]   x_raw,
  input  wire logic [fplog_pkg::MODE_W-1:0]       mode,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [fplog_pkg::RES_W-1:0]      result_raw,
  output logic                                    invalid
);

  import fplog_pkg::*;

  localparam int NSTG = 8;

  logic [NSTG:1] vld;
  logic [NSTG:1] adv;

  // stage 1
  logic              inv_s1;
  logic [MODE_W-1:0] mode_s1;
  logic [X_W-2:0]    x_s1;
  logic [N_W-1:0]    n_s1;
  // stage 2
  logic              inv_s2;
  logic [MODE_W-1:0] mode_s2;
  logic [N_W-1:0]    n_s2;
  logic [M_W-1:0]    m_s2;
  // stage 3
  logic              inv_s3;
  logic [MODE_W-1:0] mode_s3;
  logic [N_W-1:0]    n_s3;
  logic [M_W-1:0]    m_s3;
  logic [M_W-1:0]    sq_s3;
  logic [24:0]       t1_s3;
  // stage 4
  logic              inv_s4;
  logic [MODE_W-1:0] mode_s4;
  logic [N_W-1:0]    n_s4;
  logic [M_W-1:0]    m_s4;
  logic [24:0]       t1_s4;
  logic [25:0]       t2_s4;
  logic [15:0]       c3_s4;
  logic [M_W-1:0]    m4_s4;
  // stage 5
  logic              inv_s5;
  logic [MODE_W-1:0] mode_s5;
  logic [N_W-1:0]    n_s5;
  logic signed [26:0] a_s5;
  logic [25:0]       b_s5;
  logic [24:0]       c_s5;
  // stage 6
  logic              inv_s6;
  logic [MODE_W-1:0] mode_s6;
  logic signed [L2_W-1:0] l2_s6;
  // stage 7
  logic              inv_s7;
  logic [MODE_W-1:0] mode_s7;
  logic signed [L2_W-1:0] l2_s7;
  logic              neg_s7;
  logic [L2_W-2:0]   ab_s7;
  logic [15:0]       q0_s7;

  // combinational
  logic [N_W-1:0]    n_next;
  logic              inv_next;
  logic [X_W+FRAC-2:0] norm;
  logic [2*M_W-1:0]  sq_full;
  logic [2*M_W-1:0]  m4_full;
  logic [31:0]       c3_full;
  logic signed [28:0] p_sum;
  logic signed [19:0] ex;
  logic signed [19:0] l2_full;
  logic [L2_W-2:0]   ab_next;
  logic [RECIP_W+L2_W-2:0] rprod;
  logic [27:0]       qd;
  logic [27:0]       rem;
  logic [15:0]       q1;
  logic signed [RES_W+1:0] quot;
  logic signed [RES_W+1:0] pick;
  logic signed [RES_W-1:0] res_next;

  always_comb begin
    adv[NSTG] = !vld[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // leading one
  always_comb begin
    inv_next = (x_raw == '0) || x_raw[X_W-1];
    n_next   = N_W'(1);
    for (int i = 0; i < X_W - 1; i++) begin
      if (x_raw[i]) n_next = N_W'(i + 1);
    end
  end

  always_comb begin
    norm     = {x_s1, {FRAC{1'b0}}} >> n_s1;
    sq_full  = m_s2 * m_s2;
    m4_full  = sq_s3 * sq_s3;
    c3_full  = POLY_C3 * sq_s3;
    p_sum    = 29'(a_s5) + $signed({3'b000, b_s5}) - $signed({4'b0000, c_s5});
    ex       = $signed({15'd0, n_s5}) - 20'sd10;
    l2_full  = (ex <<< FRAC) - 20'(LOG2_OFFSET) + 20'(p_sum[28:FRAC]);
    ab_next  = l2_s6[L2_W-1] ? (L2_W-1)'(-l2_s6) : l2_s6[L2_W-2:0];
    rprod    = ab_next * recip_sel(mode_s6);
  end

  // remainder fix-up and output select
  always_comb begin
    qd   = q0_s7 * div_sel(mode_s7);
    rem  = {2'b00, ab_s7, {FRAC{1'b0}}} - qd;
    q1   = (rem >= {16'd0, div_sel(mode_s7)}) ? q0_s7 + 16'd1 : q0_s7;
    quot = neg_s7 ? -$signed({2'b00, q1}) : $signed({2'b00, q1});
    case (mode_s7)
      MODE_LN:    pick = quot;
      MODE_LOG10: pick = quot;
      default:    pick = 18'(l2_s7);
    endcase
    res_next = inv_s7 ? '0 : sat_res(pick);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      inv_s1  <= inv_next;
      mode_s1 <= mode;
      x_s1    <= x_raw[X_W-2:0];
      n_s1    <= n_next;
    end
    if (adv[2]) begin
      inv_s2  <= inv_s1;
      mode_s2 <= mode_s1;
      n_s2    <= n_s1;
      m_s2    <= norm[M_W-1:0];
    end
    if (adv[3]) begin
      inv_s3  <= inv_s2;
      mode_s3 <= mode_s2;
      n_s3    <= n_s2;
      m_s3    <= m_s2;
      sq_s3   <= sq_full[2*M_W-1:FRAC];
      t1_s3   <= POLY_C1 * m_s2;
    end
    if (adv[4]) begin
      inv_s4  <= inv_s3;
      mode_s4 <= mode_s3;
      n_s4    <= n_s3;
      m_s4    <= m_s3;
      t1_s4   <= t1_s3;
      t2_s4   <= POLY_C2 * sq_s3;
      c3_s4   <= c3_full[25:FRAC];
      m4_s4   <= m4_full[2*M_W-1:FRAC];
    end
    if (adv[5]) begin
      inv_s5  <= inv_s4;
      mode_s5 <= mode_s4;
      n_s5    <= n_s4;
      a_s5    <= $signed({2'b00, t1_s4}) - $signed({1'b0, t2_s4});
      b_s5    <= c3_s4 * m_s4;
      c_s5    <= POLY_C4 * m4_s4;
    end
    if (adv[6]) begin
      inv_s6  <= inv_s5;
      mode_s6 <= mode_s5;
      l2_s6   <= l2_full[L2_W-1:0];
    end
    if (adv[7]) begin
      inv_s7  <= inv_s6;
      mode_s7 <= mode_s6;
      l2_s7   <= l2_s6;
      neg_s7  <= l2_s6[L2_W-1];
      ab_s7   <= ab_next;
      q0_s7   <= rprod[RECIP_W+L2_W-2:RECIP_SHIFT];
    end
    if (adv[8]) begin
      result_raw <= res_next;
      invalid    <= inv_s7;
    end
  end

`include "assert_macros.svh"

  `ASSERT_SAME(a_stall_full, clk, rst, in_stall, out_valid && out_stall, "stall with room")
  `ASSERT_SAME(a_norm_top, clk, rst, vld[2] && !inv_s2, m_s2[M_W-1], "mantissa not normalized")
  `ASSERT_SAME(a_l2_range, clk, rst, vld[7] && !inv_s7,
    l2_s7 >= -17'sd10300 && l2_s7 <= 17'sd23000, "log2 out of range")
  `ASSERT_SAME(a_inv_zero, clk, rst, out_valid && invalid, result_raw == '0, "invalid not zero")

endmodule

`default_nettype wire
